// ===== hw/rtl/a85_pkg.sv =====
package a85_pkg;

	// Result status codes.
	localparam logic [2:0] ST_DATA       = 3'd0;
	localparam logic [2:0] ST_DONE       = 3'd1;
	localparam logic [2:0] ST_Z_IN_GROUP = 3'd2;
	localparam logic [2:0] ST_LONE_DIGIT = 3'd3;
	localparam logic [2:0] ST_INVALID    = 3'd4;

	// Characters with a meaning of their own in the text.
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [31:0] RADIX = 32'd85;

	localparam int QUEUE_DEPTH = 4;

	// One decoded action: up to four data bytes, then an optional status result.
	typedef struct packed {
		logic [31:0] word;
		logic [23:0] pad;
		logic [2:0]  nbytes;
		logic        has_status;
		logic [2:0]  status;
	} cmd_t;

	// 85 raised to the number of digits missing from a partial group.
	function automatic logic [19:0] pad_scale(input logic [2:0] cnt);
		logic [19:0] r;
		unique case (cnt)
			3'd2:    r = 20'd614125;
			3'd3:    r = 20'd7225;
			3'd4:    r = 20'd85;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

	// Fill constant added to a padded partial group.
	function automatic logic [23:0] pad_fill(input logic [2:0] cnt);
		logic [23:0] r;
		unique case (cnt)
			3'd2:    r = 24'hFFFFFF;
			3'd3:    r = 24'h00FFFF;
			3'd4:    r = 24'h0000FF;
			default: r = 24'h000000;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/ascii85_stream_decoder_core.sv =====
// A text byte accepted with the queue empty is written into the request queue, then loaded
// into the output stage, from which its first result is shown.
// Throughput: one text byte per cycle enters while the request queue has room; the
// result side delivers one result per cycle while out_ready is high and results are pending.
// A group or 'z' yields four results, five if it also ends the stream; a flush up to four.
// Reset: arst_n, asynchronous and active low, clears the digit count, accumulator and tilde flag.
module ascii85_stream_decoder_core #(
	parameter int QUEUE_DEPTH = a85_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);

	// Reset also clears the halt flag, the queue pointers and the output stage, so no
	// clearing pass is needed.

	// The front end classifies each text byte and keeps the group state. Every byte
	// that causes results becomes one request in the queue: up to four data bytes
	// and an optional closing status. Whitespace, a digit that does not close a group and
	// the first half of the end marker produce no request unless they end the stream.
	a85_pkg::cmd_t push_cmd;
	a85_pkg::cmd_t pop_cmd;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;

	a85_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.full       (full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// The queue lets the front end keep taking bytes while a burst of results drains.
	a85_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// The back end expands each request into results, one per cycle while out_ready is high,
	// from registers, and flags the final result of each request.
	a85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

endmodule

// ===== hw/rtl/a85_front.sv =====
module a85_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              stream_end,
	input  logic              full,
	output logic              push,
	output a85_pkg::cmd_t     cmd
);

	logic [2:0]  cnt_q;
	logic [31:0] acc_q;
	logic        tilde_q;
	logic        halted_q;

	logic [2:0]  cnt_d;
	logic [31:0] acc_d;
	logic        tilde_d;
	logic        halted_d;

	logic        accept;
	logic        is_digit;
	logic        is_white;
	logic [31:0] acc_next;
	logic [31:0] acc_scaled;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	assign is_digit = (in_byte >= a85_pkg::CH_EXCL) && (in_byte <= a85_pkg::CH_U);
	assign is_white = (in_byte == a85_pkg::CH_SPACE) ||
	                  ((in_byte >= a85_pkg::CH_TAB) && (in_byte <= a85_pkg::CH_CR));

	assign acc_next   = acc_q * a85_pkg::RADIX + {24'd0, in_byte - a85_pkg::CH_EXCL};
	assign acc_scaled = acc_q * {12'd0, a85_pkg::pad_scale(cnt_q)};

	always_comb begin
		cnt_d          = cnt_q;
		acc_d          = acc_q;
		tilde_d        = tilde_q;
		halted_d       = halted_q;
		cmd.word       = 32'd0;
		cmd.pad        = 24'd0;
		cmd.nbytes     = 3'd0;
		cmd.has_status = 1'b0;
		cmd.status     = a85_pkg::ST_DATA;

		if (!halted_q) begin
			if (tilde_q) begin
				tilde_d  = 1'b0;
				halted_d = 1'b1;
				cmd.has_status = 1'b1;
				if (in_byte != a85_pkg::CH_GT) begin
					cmd.status = a85_pkg::ST_INVALID;
				end else if (cnt_q == 3'd1) begin
					cmd.status = a85_pkg::ST_LONE_DIGIT;
				end else begin
					cmd.status = a85_pkg::ST_DONE;
					if (cnt_q >= 3'd2) begin
						cmd.word   = acc_scaled;
						cmd.pad    = a85_pkg::pad_fill(cnt_q);
						cmd.nbytes = cnt_q - 3'd1;
					end
				end
			end else if (in_byte == a85_pkg::CH_TILDE) begin
				if (stream_end) begin
					halted_d       = 1'b1;
					cmd.has_status = 1'b1;
					cmd.status     = a85_pkg::ST_INVALID;
				end else begin
					tilde_d = 1'b1;
				end
			end else if (is_digit) begin
				if (cnt_q == 3'd4) begin
					cmd.word   = acc_next;
					cmd.nbytes = 3'd4;
					cnt_d      = 3'd0;
					acc_d      = 32'd0;
				end else begin
					cnt_d = cnt_q + 3'd1;
					acc_d = acc_next;
				end
			end else if (in_byte == a85_pkg::CH_Z) begin
				if (cnt_q != 3'd0) begin
					halted_d       = 1'b1;
					cmd.has_status = 1'b1;
					cmd.status     = a85_pkg::ST_Z_IN_GROUP;
				end else begin
					cmd.nbytes = 3'd4;
				end
			end else if (!is_white) begin
				halted_d       = 1'b1;
				cmd.has_status = 1'b1;
				cmd.status     = a85_pkg::ST_INVALID;
			end
		end

		// Every status code halts, so a closing done never meets another status.
		if (stream_end) begin
			if (!halted_d) begin
				cmd.has_status = 1'b1;
				cmd.status     = a85_pkg::ST_DONE;
			end
			cnt_d    = 3'd0;
			acc_d    = 32'd0;
			tilde_d  = 1'b0;
			halted_d = 1'b0;
		end
	end

	assign push = accept && (cmd.has_status || (cmd.nbytes != 3'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 3'd0;
			acc_q    <= 32'd0;
			tilde_q  <= 1'b0;
			halted_q <= 1'b0;
		end else if (accept) begin
			cnt_q    <= cnt_d;
			acc_q    <= acc_d;
			tilde_q  <= tilde_d;
			halted_q <= halted_d;
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("digit count out of range");
	a_halt_tilde: assert property (@(posedge clk) disable iff (!arst_n) !(halted_q && tilde_q))
		else $error("tilde pending while halted");
	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_end |=> (cnt_q == 3'd0) && !halted_q && !tilde_q && (acc_q == 32'd0))
		else $error("state not cleared after stream end");
`endif

endmodule

// ===== hw/rtl/a85_queue.sv =====
module a85_queue #(
	parameter int DEPTH = a85_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  a85_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output a85_pkg::cmd_t pop_cmd,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	a85_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == CW'(0));
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/a85_back.sv =====
module a85_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  a85_pkg::cmd_t pop_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic [2:0]    status,
	output logic          last
);

	logic        busy_q;
	logic [31:0] word_q;
	logic [2:0]  rem_q;
	logic        has_st_q;
	logic [2:0]  st_q;

	logic        take;
	logic        final_res;

	assign out_valid = busy_q;
	assign final_res = (rem_q == 3'd0) || ((rem_q == 3'd1) && !has_st_q);
	assign out_byte  = (rem_q != 3'd0) ? word_q[31:24] : 8'd0;
	assign status    = (rem_q != 3'd0) ? a85_pkg::ST_DATA : st_q;
	assign last      = final_res;

	assign take = out_valid && out_ready;
	assign pop  = !empty && (!busy_q || (take && final_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (take && final_res) begin
			busy_q <= 1'b0;
		end
	end

	// The fill constant of a padded group is added as the request is loaded.
	always_ff @(posedge clk) begin
		if (pop) begin
			word_q   <= pop_cmd.word + {8'd0, pop_cmd.pad};
			rem_q    <= pop_cmd.nbytes;
			has_st_q <= pop_cmd.has_status;
			st_q     <= pop_cmd.status;
		end else if (take && (rem_q != 3'd0)) begin
			word_q <= {word_q[23:0], 8'd0};
			rem_q  <= rem_q - 3'd1;
		end
	end

`ifndef SYNTH
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> rem_q <= 3'd4)
		else $error("byte count out of range");
	a_no_empty_req: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (rem_q == 3'd0) |-> has_st_q)
		else $error("request with no result left");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule
